// ----- src/srth_pkg.sv -----
package srth_pkg;

	// table geometry: 256 rows by 256 columns
	localparam int unsigned ROW_W    = 8;
	localparam int unsigned COL_W    = 8;
	localparam int unsigned TABLE_AW = ROW_W + COL_W;
	localparam int unsigned TABLE_DEPTH = 1 << TABLE_AW;
	localparam int unsigned WORD_W   = 32;

	// item fields
	localparam int unsigned SHAPE_W = 32;
	localparam int unsigned BYTE_W  = 8;

	// defaults for top level parameters
	localparam int unsigned RECORD_BYTES_DEF = 36;
	localparam int unsigned QUEUE_DEPTH_DEF  = 4;

	// truncated 15-bit generator
	localparam logic [31:0] LCG_MUL  = 32'h0003_43FD;
	localparam logic [31:0] LCG_ADD  = 32'h0026_9EC3;
	localparam int unsigned LCG_W    = 15;
	localparam logic [LCG_W-1:0] LCG_SEED = 15'd1;

	// generator steps packed into one table word
	localparam logic [1:0] STEP_B0 = 2'd0;
	localparam logic [1:0] STEP_B1 = 2'd1;
	localparam logic [1:0] STEP_B2 = 2'd2;
	localparam logic [1:0] STEP_B3 = 2'd3;

	// request queued between front and back
	typedef struct packed {
		logic [TABLE_AW-1:0] addr;
		logic                last;
	} lookup_t;

	// table write from the load sequencer
	typedef struct packed {
		logic                en;
		logic [TABLE_AW-1:0] addr;
		logic [WORD_W-1:0]   data;
	} tbl_wr_t;

endpackage

// ----- src/srth_ram.sv -----
module srth_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/srth_fill.sv -----
module srth_fill (
	input  logic             clk,
	input  logic             arst_n,
	output srth_pkg::tbl_wr_t wr,
	output logic             done
);

	localparam int unsigned AW = srth_pkg::TABLE_AW;

	logic [srth_pkg::LCG_W-1:0] lcg_q;
	logic [srth_pkg::LCG_W-1:0] lcg_next;
	logic [31:0]                lcg_prod;
	logic [1:0]                 step_q;
	logic [23:0]                acc_q;
	logic [AW:0]                idx_q;

	assign done = idx_q[AW];

	// one generator step per cycle
	assign lcg_prod = 32'(lcg_q) * srth_pkg::LCG_MUL + srth_pkg::LCG_ADD;
	assign lcg_next = lcg_prod[30:16];

	// fourth step completes a word
	assign wr.en   = !done && (step_q == srth_pkg::STEP_B3);
	assign wr.addr = idx_q[AW-1:0];
	assign wr.data = {lcg_next[7:0], acc_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcg_q  <= srth_pkg::LCG_SEED;
			step_q <= srth_pkg::STEP_B0;
			idx_q  <= '0;
		end else if (!done) begin
			lcg_q  <= lcg_next;
			step_q <= step_q + 2'd1;
			if (step_q == srth_pkg::STEP_B3) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// byte collection of the word in progress
	always_ff @(posedge clk) begin
		case (step_q)
			srth_pkg::STEP_B0: acc_q[7:0]   <= lcg_next[7:0];
			srth_pkg::STEP_B1: acc_q[15:8]  <= lcg_next[7:0];
			srth_pkg::STEP_B2: acc_q[23:16] <= lcg_next[7:0];
			default:           acc_q        <= acc_q;
		endcase
	end

endmodule

// ----- src/srth_front.sv -----
module srth_front #(
	parameter int unsigned RECORD_BYTES = srth_pkg::RECORD_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [srth_pkg::SHAPE_W-1:0] shape_id,
	input  logic [srth_pkg::BYTE_W-1:0]  record_byte,
	input  logic                         last_of_slide,
	input  logic                         table_ready,
	input  logic                         queue_full,
	output logic                         push,
	output srth_pkg::lookup_t            entry
);

	localparam int unsigned PW = $clog2(RECORD_BYTES + 1);

	logic [PW-1:0]                         pos_q;
	logic [PW-1:0]                         mult;
	logic [srth_pkg::ROW_W+PW-1:0]         prod;
	logic [srth_pkg::ROW_W-1:0]            row;

	// no requests until the table is loaded
	assign in_stall = !table_ready || queue_full;
	assign push     = in_valid && !in_stall;

	// row = shape id times byte index plus one, mod 256
	assign mult = pos_q + 1'b1;
	assign prod = (srth_pkg::ROW_W+PW)'(shape_id[srth_pkg::ROW_W-1:0])
		* (srth_pkg::ROW_W+PW)'(mult);
	assign row  = prod[srth_pkg::ROW_W-1:0];

	assign entry.addr = {row, record_byte};
	assign entry.last = last_of_slide;

	// byte index within the record, restarts at end of slide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			if (last_of_slide || mult == PW'(RECORD_BYTES)) begin
				pos_q <= '0;
			end else begin
				pos_q <= mult;
			end
		end
	end

endmodule

// ----- src/srth_queue.sv -----
module srth_queue #(
	parameter int unsigned DEPTH = srth_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  srth_pkg::lookup_t push_data,
	input  logic              pop,
	output srth_pkg::lookup_t head,
	output logic              empty,
	output logic              full
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	srth_pkg::lookup_t slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));
	assign head  = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- src/srth_back.sv -----
module srth_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        queue_empty,
	input  srth_pkg::lookup_t           head,
	output logic                        pop,
	output logic                        rd_en,
	output logic [srth_pkg::TABLE_AW-1:0] rd_addr,
	input  logic [srth_pkg::WORD_W-1:0] rd_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [srth_pkg::WORD_W-1:0] slide_hash
);

	logic                        valid_s2;
	logic                        last_s2;
	logic                        advance;
	logic [srth_pkg::WORD_W-1:0] hash_q;
	logic [srth_pkg::WORD_W-1:0] out_hash_q;
	logic                        out_valid_q;

	// read stage holds only when a finished hash cannot leave
	assign advance = !(valid_s2 && last_s2 && out_valid_q && out_stall);
	assign pop     = advance && !queue_empty;
	assign rd_en   = pop;
	assign rd_addr = head.addr;

	assign out_valid  = out_valid_q;
	assign slide_hash = out_hash_q;

	// read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
		end else if (advance) begin
			valid_s2 <= pop;
			last_s2  <= head.last;
		end
	end

	// running hash and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (valid_s2 && advance && last_s2) begin
				hash_q      <= '0;
				out_valid_q <= 1'b1;
			end else begin
				if (valid_s2 && advance) begin
					hash_q <= hash_q ^ rd_data;
				end
				if (!out_stall) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && advance && last_s2) begin
			out_hash_q <= hash_q ^ rd_data;
		end
	end

endmodule

// ----- src/shape_record_tabulation_hash_unit.sv -----
// Tabulation hash over the animation record bytes of a slide. Each accepted
// request carries one record byte with its shape id; the block looks up a
// 32-bit word in a 65536-entry table at row (shape id times byte index plus
// one, mod 256) and column (byte value), XORs it into a running hash, and on
// the request flagged last_of_slide delivers the hash and clears it. Byte
// index counts 0 to RECORD_BYTES-1 and restarts at the end of a slide. After
// reset the table is loaded from a 15-bit generator that takes one step per
// cycle and needs four steps per word; in_stall stays high until the whole
// table is loaded. Once loaded, one request is taken every cycle while the
// queue is not full; the rate is set by the single read port of the table,
// which serves one lookup per cycle. The last request of a slide is written
// into the queue on the edge that takes it, then read from the table, then
// its hash goes into the result register. A stalled result holds the back
// end only once the next last_of_slide request reaches the table read stage;
// the front keeps taking requests until the QUEUE_DEPTH-entry queue is full.
module shape_record_tabulation_hash_unit #(
	parameter int unsigned RECORD_BYTES = srth_pkg::RECORD_BYTES_DEF,
	parameter int unsigned QUEUE_DEPTH  = srth_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [srth_pkg::SHAPE_W-1:0] shape_id,
	input  logic [srth_pkg::BYTE_W-1:0]  record_byte,
	input  logic                         last_of_slide,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [srth_pkg::WORD_W-1:0]  slide_hash
);

	srth_pkg::tbl_wr_t             tbl_wr;
	logic                          table_ready;
	logic                          push;
	srth_pkg::lookup_t             push_entry;
	logic                          pop;
	srth_pkg::lookup_t             head;
	logic                          queue_empty;
	logic                          queue_full;
	logic                          rd_en;
	logic [srth_pkg::TABLE_AW-1:0] rd_addr;
	logic [srth_pkg::WORD_W-1:0]   rd_data;

	// table load after reset
	srth_fill u_fill (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (tbl_wr),
		.done   (table_ready)
	);

	// random word table
	srth_ram #(
		.WIDTH (srth_pkg::WORD_W),
		.DEPTH (srth_pkg::TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (tbl_wr.en),
		.waddr (tbl_wr.addr),
		.wdata (tbl_wr.data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// request intake and address forming
	srth_front #(
		.RECORD_BYTES (RECORD_BYTES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.shape_id      (shape_id),
		.record_byte   (record_byte),
		.last_of_slide (last_of_slide),
		.table_ready   (table_ready),
		.queue_full    (queue_full),
		.push          (push),
		.entry         (push_entry)
	);

	// lookups waiting for the back end
	srth_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_entry),
		.pop       (pop),
		.head      (head),
		.empty     (queue_empty),
		.full      (queue_full)
	);

	// table read, hash accumulate, result
	srth_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.head        (head),
		.pop         (pop),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.slide_hash  (slide_hash)
	);

endmodule

// ----- test/srth_hash_checker.sv -----
`timescale 1ns / 100ps

// watches both channels, tracks the slide hash and compares each delivered result
module srth_hash_checker #(
	parameter int unsigned RECORD_BYTES = srth_pkg::RECORD_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [srth_pkg::SHAPE_W-1:0] shape_id,
	input  logic [srth_pkg::BYTE_W-1:0]  record_byte,
	input  logic                         last_of_slide,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [srth_pkg::WORD_W-1:0]  slide_hash,
	output int                           fail_count,
	output int                           pending
);

	localparam logic [31:0] GEN_MASK = (32'd1 << srth_pkg::LCG_W) - 32'd1;
	localparam int unsigned STEPS_PER_WORD = srth_pkg::WORD_W / 8;

	logic [srth_pkg::WORD_W-1:0] zobrist_words [srth_pkg::TABLE_DEPTH];
	logic [srth_pkg::WORD_W-1:0] hash_acc;
	logic [5:0]                  byte_pos;
	logic [srth_pkg::ROW_W-1:0]  row;
	logic [srth_pkg::WORD_W-1:0] want;
	logic [srth_pkg::WORD_W-1:0] hash_due [$];

	// rebuild the lookup table from the 15-bit generator
	initial begin
		logic [31:0] gen;
		logic [31:0] mixed;
		logic [srth_pkg::WORD_W-1:0] word;
		fail_count = 0;
		pending = 0;
		hash_acc = '0;
		byte_pos = '0;
		gen = 32'(srth_pkg::LCG_SEED);
		for (int k = 0; k < srth_pkg::TABLE_DEPTH; k++) begin
			word = '0;
			for (int b = 0; b < STEPS_PER_WORD; b++) begin
				mixed = gen * srth_pkg::LCG_MUL + srth_pkg::LCG_ADD;
				gen = (mixed >> 16) & GEN_MASK;
				word[8*b +: 8] = gen[7:0];
			end
			zobrist_words[k] = word;
		end
	end

	// compare delivered hashes, then fold in the accepted request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_acc = '0;
			byte_pos = '0;
			hash_due.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (hash_due.size() == 0) begin
					$error("slide_hash: expected none, got %h", slide_hash);
					fail_count++;
				end else begin
					want = hash_due.pop_front();
					if (slide_hash !== want) begin
						$error("slide_hash: expected %h, got %h", want, slide_hash);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				// row from the low shape id byte times byte index plus one
				row = shape_id[7:0] * (8'(byte_pos) + 8'd1);
				hash_acc ^= zobrist_words[{row, record_byte}];
				byte_pos++;
				if (byte_pos >= RECORD_BYTES)
					byte_pos = '0;
				// end of slide, even in mid record
				if (last_of_slide) begin
					hash_due = {hash_due, hash_acc};
					hash_acc = '0;
					byte_pos = '0;
				end
			end
			pending = hash_due.size();
		end
	end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;

	localparam int unsigned WATCHDOG_LIMIT = 800_000;
	localparam int unsigned ITEM_TARGET    = 900;
	localparam int unsigned SLIDE_TARGET   = 20;
	localparam int unsigned SETTLE_CYCLES  = 20;
	localparam int unsigned PAUSE_SLIDE    = 12;

	localparam logic [1:0] STALL_NONE  = 2'd0;
	localparam logic [1:0] STALL_LIGHT = 2'd1;
	localparam logic [1:0] STALL_HEAVY = 2'd2;
	localparam logic [1:0] STALL_BEAT  = 2'd3;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic [srth_pkg::SHAPE_W-1:0] shape_id;
	logic [srth_pkg::BYTE_W-1:0]  record_byte;
	logic                         last_of_slide;
	logic                         out_valid;
	logic                         out_stall;
	logic [srth_pkg::WORD_W-1:0]  slide_hash;
	int                           fail_count;
	int                           pending;

	int unsigned burst_left;
	int unsigned items_sent;
	int unsigned slides_sent;
	int unsigned idle_cycles;
	logic [31:0] stall_clock;

	shape_record_tabulation_hash_unit #(
		.RECORD_BYTES(srth_pkg::RECORD_BYTES_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.shape_id(shape_id),
		.record_byte(record_byte),
		.last_of_slide(last_of_slide),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.slide_hash(slide_hash)
	);

	srth_hash_checker #(
		.RECORD_BYTES(srth_pkg::RECORD_BYTES_DEF)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.shape_id(shape_id),
		.record_byte(record_byte),
		.last_of_slide(last_of_slide),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.slide_hash(slide_hash),
		.fail_count(fail_count),
		.pending(pending)
	);

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// result stall pattern, phase taken from bits 9:8 of stall_clock
	always @(negedge clk) begin
		stall_clock <= stall_clock + 32'd1;
		case (stall_clock[9:8])
			STALL_NONE: begin
				out_stall <= 1'b0;
			end
			STALL_LIGHT: begin
				out_stall <= ($urandom_range(0, 99) < 25);
			end
			STALL_HEAVY: begin
				out_stall <= ($urandom_range(0, 99) < 85);
			end
			default: begin
				out_stall <= stall_clock[2];
			end
		endcase
	end

	// hang detection: no request and no result for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// one request, with bursts and random gaps in front of it
	task automatic send_byte(input logic [srth_pkg::SHAPE_W-1:0] sid,
			input logic [srth_pkg::BYTE_W-1:0] val, input logic last);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 7);
			burst_left = $urandom_range(1, 48);
			if (gap != 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		shape_id <= sid;
		record_byte <= val;
		last_of_slide <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		if (last)
			slides_sent++;
	endtask

	// hold off until every pending hash has been delivered
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		burst_left = 0;
	endtask

	// one random slide: mostly whole records, some cut short with noisy ids
	task automatic send_slide();
		int unsigned kind;
		int unsigned n_rec;
		int unsigned len;
		logic [srth_pkg::SHAPE_W-1:0] sid;
		logic blank;
		kind = $urandom_range(0, 99);
		if (kind < 65) begin
			n_rec = (kind < 50) ? 1 : $urandom_range(2, 3);
			for (int r = 0; r < n_rec; r++) begin
				sid = ($urandom_range(0, 9) == 0) ? {srth_pkg::SHAPE_W{1'b1}} : $urandom();
				blank = ($urandom_range(0, 3) == 0);
				for (int i = 0; i < srth_pkg::RECORD_BYTES_DEF; i++)
					send_byte(sid, blank ? 8'd0 : 8'($urandom_range(0, 255)),
						(r == n_rec - 1) && (i == srth_pkg::RECORD_BYTES_DEF - 1));
			end
		end else begin
			len = $urandom_range(1, 40);
			sid = $urandom();
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 7) == 0)
					sid = $urandom();
				send_byte(sid, 8'($urandom_range(0, 255)), i == len - 1);
			end
		end
	endtask

	initial begin
		int unsigned random_slides;
		arst_n = 1'b0;
		in_valid = 1'b0;
		shape_id = '0;
		record_byte = '0;
		last_of_slide = 1'b0;
		out_stall = 1'b0;
		stall_clock = '0;
		burst_left = 0;
		items_sent = 0;
		slides_sent = 0;
		idle_cycles = 0;
		random_slides = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// single-byte slides at the field extremes
		send_byte(32'h0000_0000, 8'h00, 1'b1);
		send_byte(32'hFFFF_FFFF, 8'hFF, 1'b1);
		// shape change inside a record, slide ends early
		send_byte(32'h1234_5678, 8'h5A, 1'b0);
		send_byte(32'h1234_5678, 8'hA5, 1'b0);
		send_byte(32'h0000_00A5, 8'h80, 1'b0);
		send_byte(32'h0000_00A5, 8'h01, 1'b0);
		send_byte(32'h8000_0001, 8'h7F, 1'b1);
		// shape with no record: zero bytes
		for (int i = 0; i < 4; i++)
			send_byte(32'hFFFF_FF00, 8'h00, 1'b0);
		send_byte(32'hFFFF_FF00, 8'h00, 1'b1);
		// same slide twice: hash must clear between slides
		for (int s = 0; s < 2; s++) begin
			send_byte(32'd7, 8'd1, 1'b0);
			send_byte(32'd7, 8'd2, 1'b0);
			send_byte(32'd7, 8'd3, 1'b1);
		end
		wait_idle();

		// random slides, with one full pause part way through
		while (items_sent < ITEM_TARGET || random_slides < SLIDE_TARGET) begin
			send_slide();
			random_slides++;
			if (random_slides == PAUSE_SLIDE)
				wait_idle();
		end
		wait_idle();
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
